// File: rtl/core/kens_pkg.sv
// ----------------------------------------------------------------------------
// Kepler solver package
// Shared angle formats, the CORDIC arctangent table and the fixed constants
// of the Newton solver.
// ----------------------------------------------------------------------------
package kens_pkg;

  // Angle format and CORDIC length.
  localparam int ANGLE_FRAC_BITS = 28;
  localparam int CORDIC_STEPS    = 30;
  localparam int CNT_W           = $clog2(CORDIC_STEPS);

  // Reduced angle width and sine/cosine width (Q30 with headroom).
  localparam int RED_W = 33;
  localparam int SC_W  = 34;

  // Iteration count width and the hard cap on Newton steps.
  localparam int ITER_W = 7;
  localparam logic [ITER_W-1:0] ITER_LIMIT = 7'd64;

  typedef logic signed [RED_W-1:0] red_t;
  typedef logic signed [SC_W-1:0]  sc_t;
  typedef red_t [CORDIC_STEPS-1:0] atan_tab_t;

  // Pi in Q62.
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;

  // Round a Q62 value half up to the angle format.
  function automatic logic [63:0] q62_to_angle(input logic [63:0] v);
    return (v + (64'd1 << (61 - ANGLE_FRAC_BITS))) >> (62 - ANGLE_FRAC_BITS);
  endfunction

  // Divide by the odd number 2k+1 of the arctangent series.
  function automatic logic [63:0] odd_div(input logic [63:0] v, input int k);
    case (k)
      0:       return v;
      1:       return v / 64'd3;
      2:       return v / 64'd5;
      3:       return v / 64'd7;
      4:       return v / 64'd9;
      5:       return v / 64'd11;
      6:       return v / 64'd13;
      7:       return v / 64'd15;
      8:       return v / 64'd17;
      9:       return v / 64'd19;
      10:      return v / 64'd21;
      11:      return v / 64'd23;
      12:      return v / 64'd25;
      13:      return v / 64'd27;
      14:      return v / 64'd29;
      15:      return v / 64'd31;
      16:      return v / 64'd33;
      17:      return v / 64'd35;
      18:      return v / 64'd37;
      19:      return v / 64'd39;
      20:      return v / 64'd41;
      21:      return v / 64'd43;
      22:      return v / 64'd45;
      23:      return v / 64'd47;
      24:      return v / 64'd49;
      25:      return v / 64'd51;
      26:      return v / 64'd53;
      27:      return v / 64'd55;
      28:      return v / 64'd57;
      29:      return v / 64'd59;
      30:      return v / 64'd61;
      default: return v;
    endcase
  endfunction

  // Arctangent table, built from the Q62 series at elaboration.
  function automatic atan_tab_t build_atan();
    atan_tab_t   tab;
    logic [63:0] sum;
    logic [63:0] t;
    int          sh;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) begin
        sum = PI_Q62 >> 2;
      end else begin
        sum = '0;
        for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
          sh = 62 - i * (2 * k + 1);
          t  = odd_div(64'd1 << sh, k);
          if (k[0]) begin
            sum = sum - t;
          end else begin
            sum = sum + t;
          end
        end
      end
      tab[i] = RED_W'(q62_to_angle(sum));
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan();

  localparam logic [63:0] PI_WIDE = q62_to_angle(PI_Q62);
  localparam red_t PI_ANG  = RED_W'(PI_WIDE);
  localparam red_t TWO_PI  = RED_W'(PI_WIDE << 1);
  localparam red_t HALF_PI = RED_W'(PI_WIDE >> 1);

  // CORDIC gain in Q30, start value of the x vector.
  localparam sc_t CORDIC_GAIN = 34'sd652032874;

endpackage

// File: rtl/core/kepler_equation_newton_solver.sv
// Each item takes from 1 to 64 Newton steps, and one item is in flight at a time.
// Reset clears the sequencer and the output valid, and loads eccentricity 0,
// tolerance 27 and an iteration limit of 16.
// ----------------------------------------------------------------------------
// Kepler equation Newton solver
// Solves M = E - e sin E for E by Newton steps on a shared CORDIC, a shared
// multiplier and a serial divider, under one sequencer.
// ----------------------------------------------------------------------------
module kepler_equation_newton_solver (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] mean_anomaly_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] eccentric_anomaly_o,
  output logic [6:0]         iterations_used_o,
  output logic               converged_o
);
  import kens_pkg::*;

  localparam int ES_SH = 60 - ANGLE_FRAC_BITS;
  localparam int F_W   = 35;

  typedef enum logic [1:0] {
    REG_ECC   = 2'd0,
    REG_TOL   = 2'd1,
    REG_MAXIT = 2'd2
  } reg_idx_e;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_SINCOS = 8'b00000010,
    S_MUL_S  = 8'b00000100,
    S_MUL_C  = 8'b00001000,
    S_FUNC   = 8'b00010000,
    S_DIV    = 8'b00100000,
    S_UPDATE = 8'b01000000,
    S_FIN    = 8'b10000000
  } state_e;

  // Configuration registers.
  logic [29:0]       ecc_q;
  logic [28:0]       tol_q;
  logic [ITER_W-1:0] maxit_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecc_q   <= '0;
      tol_q   <= 29'd27;
      maxit_q <= 7'd16;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_ECC:   ecc_q   <= pwdata[29:0];
        REG_TOL:   tol_q   <= pwdata[28:0];
        REG_MAXIT: maxit_q <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_ECC:   prdata = {2'b00, ecc_q};
      REG_TOL:   prdata = {3'b000, tol_q};
      REG_MAXIT: prdata = {25'd0, maxit_q};
      default:   prdata = '0;
    endcase
  end

  // Sequencer state and item registers.
  state_e             state_q;
  logic               accept;
  logic signed [31:0] m_q, e_q;
  logic [ITER_W-1:0]  n_q, limit_q, limit_d;
  logic               conv_q, fpos_q;
  logic               out_valid_q, out_conv_q;
  logic signed [31:0] out_e_q;
  logic [ITER_W-1:0]  out_n_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Clamp the iteration limit to one through the hard cap.
  always_comb begin
    if (maxit_q == '0) begin
      limit_d = 7'd1;
    end else if (maxit_q > ITER_LIMIT) begin
      limit_d = ITER_LIMIT;
    end else begin
      limit_d = maxit_q;
    end
  end

  // Shared sine/cosine unit.
  logic               cs_start, cs_done;
  logic signed [31:0] cs_angle;
  sc_t                sin_w, cos_w;

  kens_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cs_start),
    .angle_i (cs_angle),
    .done_o  (cs_done),
    .sin_o   (sin_w),
    .cos_o   (cos_w)
  );

  // Shared multiplier: e*sin first, then e*cos.
  logic signed [30:0]       mul_a;
  sc_t                      mul_b;
  logic signed [64:0]       prod_d, prod_q;
  logic signed [64:0]       es_sum, ec_sum;
  logic signed [64-ES_SH:0] es_d, es_q;
  logic signed [34:0]       ec_d;
  logic signed [35:0]       fp_d;
  logic [31:0]              den_d;
  logic signed [F_W-1:0]    f_d, f_abs;
  logic [32:0]              num_d;

  assign mul_a  = $signed({1'b0, ecc_q});
  assign mul_b  = (state_q == S_MUL_S) ? sin_w : cos_w;
  assign prod_d = mul_a * mul_b;

  // Round both products half up into their formats.
  assign es_sum = prod_q + (65'sd1 <<< (ES_SH - 1));
  assign es_d   = es_sum[64:ES_SH];
  assign ec_sum = prod_q + (65'sd1 <<< 29);
  assign ec_d   = ec_sum[64:30];

  // Derivative with its floor, residual and its magnitude.
  assign fp_d  = (36'sd1 <<< 30) - 36'(ec_d);
  assign den_d = (fp_d < 36'sd1) ? 32'd1 : fp_d[31:0];
  assign f_d   = F_W'(e_q) - F_W'(es_q) - F_W'(m_q);
  assign f_abs = (f_d < 0) ? -f_d : f_d;
  assign num_d = f_abs[32:0];

  // Serial divider for the step size.
  logic        div_start, div_done;
  logic [31:0] quot_w;

  assign div_start = (state_q == S_FUNC);

  kens_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_d),
    .den_i   (den_d),
    .done_o  (div_done),
    .quot_o  (quot_w)
  );

  // Newton update with saturation to 32 bits.
  logic signed [33:0] e_wide, q_ext, e_sum;
  logic signed [31:0] e_sat;
  logic [ITER_W-1:0]  n_next;
  logic               step_conv, finish;

  assign e_wide = 34'(e_q);
  assign q_ext  = $signed({2'b00, quot_w});
  assign e_sum  = fpos_q ? (e_wide - q_ext) : (e_wide + q_ext);
  assign e_sat  = (e_sum > 34'sd2147483647)  ? 32'sh7FFF_FFFF :
                  (e_sum < -34'sd2147483648) ? 32'sh8000_0000 : e_sum[31:0];
  assign n_next    = n_q + 1'b1;
  assign step_conv = (quot_w < {3'b000, tol_q});
  assign finish    = step_conv || (n_next == limit_q);

  assign cs_start = accept || (state_q == S_UPDATE && !finish);
  assign cs_angle = accept ? mean_anomaly_i : e_sat;

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      limit_q     <= 7'd1;
    end else begin
      // A new result item loads, or a stalled one is held.
      out_valid_q <= (state_q == S_FIN && out_free) || (out_valid_q && out_stall_i);
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            n_q     <= '0;
            limit_q <= limit_d;
            state_q <= S_SINCOS;
          end
        end
        S_SINCOS: if (cs_done) state_q <= S_MUL_S;
        S_MUL_S:  state_q <= S_MUL_C;
        S_MUL_C:  state_q <= S_FUNC;
        S_FUNC:   state_q <= S_DIV;
        S_DIV:    if (div_done) state_q <= S_UPDATE;
        S_UPDATE: begin
          n_q     <= n_next;
          state_q <= finish ? S_FIN : S_SINCOS;
        end
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Item datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_q <= mean_anomaly_i;
      e_q <= mean_anomaly_i;
    end
    if (state_q == S_MUL_S) prod_q <= prod_d;
    if (state_q == S_MUL_C) begin
      es_q   <= es_d;
      prod_q <= prod_d;
    end
    if (state_q == S_FUNC) fpos_q <= (f_d > 0);
    if (state_q == S_UPDATE) begin
      e_q    <= e_sat;
      conv_q <= step_conv;
    end
    if (state_q == S_FIN && out_free) begin
      out_e_q    <= e_q;
      out_n_q    <= n_q;
      out_conv_q <= conv_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign eccentric_anomaly_o = out_e_q;
  assign iterations_used_o   = out_n_q;
  assign converged_o         = out_conv_q;

`ifndef ASSERT_OFF
  // The sine/cosine unit reports only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cs_done |-> (state_q == S_SINCOS))
    else $error("sine/cosine result outside of its wait state");

  // The divider reports only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider result outside of its wait state");

  // The step count never passes the clamped limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (n_q <= limit_q && limit_q <= ITER_LIMIT))
    else $error("Newton step count beyond its limit");

  // A delivered item has run at least one step and at most the cap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (iterations_used_o >= 7'd1 && iterations_used_o <= ITER_LIMIT))
    else $error("result item with an impossible step count");
`endif

endmodule

// File: rtl/core/kens_cordic.sv
// ----------------------------------------------------------------------------
// Kepler solver sine/cosine unit
// Range reduction followed by a rotation-mode CORDIC, one micro-rotation per
// cycle on a single shift-add datapath.
// ----------------------------------------------------------------------------
module kens_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [31:0]  angle_i,
  output logic                done_o,
  output kens_pkg::sc_t       sin_o,
  output kens_pkg::sc_t       cos_o
);
  import kens_pkg::*;

  typedef enum logic [5:0] {
    C_IDLE = 6'b000001,
    C_MOD  = 6'b000010,
    C_WRAP = 6'b000100,
    C_FOLD = 6'b001000,
    C_ITER = 6'b010000,
    C_FIN  = 6'b100000
  } cstate_e;

  cstate_e            state_q, state_d;
  logic [CNT_W-1:0]   cnt_q;
  logic               done_q;
  red_t               r_q;
  sc_t                x_q, y_q, sin_q, cos_q;
  logic               flip_q;
  sc_t                dx, dy;
  logic               last_step;

  assign last_step = (cnt_q == CNT_W'(CORDIC_STEPS - 1));
  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      C_IDLE: if (start_i) state_d = C_MOD;
      C_MOD:  state_d = C_WRAP;
      C_WRAP: state_d = C_FOLD;
      C_FOLD: state_d = C_ITER;
      C_ITER: if (last_step) state_d = C_FIN;
      C_FIN:  state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == C_FIN);
      if (state_q == C_FOLD) begin
        cnt_q <= '0;
      end else if (state_q == C_ITER && !last_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Angle reduction and micro-rotations.
  always_ff @(posedge clk_i) begin
    case (state_q)
      C_IDLE: begin
        if (start_i) r_q <= {angle_i[31], angle_i};
      end
      C_MOD: begin
        if (r_q >= TWO_PI) begin
          r_q <= r_q - TWO_PI;
        end else if (r_q <= -TWO_PI) begin
          r_q <= r_q + TWO_PI;
        end
      end
      C_WRAP: begin
        if (r_q > PI_ANG) begin
          r_q <= r_q - TWO_PI;
        end else if (r_q < -PI_ANG) begin
          r_q <= r_q + TWO_PI;
        end
      end
      C_FOLD: begin
        x_q    <= CORDIC_GAIN;
        y_q    <= '0;
        flip_q <= 1'b0;
        if (r_q > HALF_PI) begin
          r_q    <= r_q - PI_ANG;
          flip_q <= 1'b1;
        end else if (r_q < -HALF_PI) begin
          r_q    <= r_q + PI_ANG;
          flip_q <= 1'b1;
        end
      end
      C_ITER: begin
        if (r_q >= 0) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          r_q <= r_q - ATAN_TAB[cnt_q];
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          r_q <= r_q + ATAN_TAB[cnt_q];
        end
      end
      C_FIN: begin
        sin_q <= flip_q ? -y_q : y_q;
        cos_q <= flip_q ? -x_q : x_q;
      end
      default: begin
      end
    endcase
  end

  assign done_o = done_q;
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;

endmodule

// File: rtl/core/kens_div.sv
// ----------------------------------------------------------------------------
// Kepler solver step divider
// Restoring divider that forms |f| * 2^30 / f' one quotient bit per cycle,
// with the result capped at 2^31.
// ----------------------------------------------------------------------------
module kens_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quot_o
);
  import kens_pkg::*;

  localparam logic [31:0] STEP_CAP = 32'h8000_0000;

  logic        busy_q, done_q, sat_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q, lo_q, den_q;
  logic [32:0] trial, diff;
  logic        ge;

  assign trial = {rem_q, lo_q[31]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  // Control: a fixed run of 32 quotient bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i[32:2]};
      lo_q  <= {num_i[1:0], 30'd0};
      den_q <= den_i;
      // A quotient of 2^32 or more can only saturate.
      sat_q <= ({1'b0, num_i} >= {den_i, 2'b00});
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      lo_q  <= {lo_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = (sat_q || lo_q > STEP_CAP) ? STEP_CAP : lo_q;

endmodule

// File: test/kepler_equation_newton_solver_test.sv
// ----------------------------------------------------------------------------
// Kepler equation Newton solver testbench
// Drives mean anomalies into the solver under several register settings,
// predicts each solved eccentric anomaly with an independent fixed-point
// Newton model, and checks every result item in order against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module kepler_equation_newton_solver_test;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int ADDR_ECC  = 0;
  localparam int ADDR_TOL  = 4;
  localparam int ADDR_ITER = 8;
  localparam int ANG_FRAC  = 28;
  localparam int ROT_STEPS = 30;
  localparam longint unsigned PI_Q62_VAL = 64'hC90FDAA22168C234;

  typedef struct packed {
    logic signed [31:0] anomaly;
    logic [6:0]         steps;
    logic               converged;
  } solution_t;

  // Newton predictor and the queue of pending solutions.
  class kepler_scoreboard;
    longint          atan_q[ROT_STEPS];
    longint          gain;
    longint          pi_val;
    longint unsigned ecc;
    longint unsigned tol;
    int unsigned     iter_max;
    solution_t       pending[$];
    int              errors;

    function new();
      longint unsigned p;
      longint unsigned root;
      longint unsigned sum;
      longint unsigned cand;
      p = 64'd1 << 62;
      root = 0;
      errors = 0;
      ecc = 0;
      tol = 27;
      iter_max = 16;
      pi_val = longint'((PI_Q62_VAL + (64'd1 << (61 - ANG_FRAC))) >> (62 - ANG_FRAC));
      for (int i = 0; i < ROT_STEPS; i++) begin
        sum = 0;
        if (i == 0) begin
          sum = PI_Q62_VAL >> 2;
        end else begin
          for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
            if (k % 2 == 1) begin
              sum -= (64'd1 << (62 - i * (2 * k + 1))) / longint'(2 * k + 1);
            end else begin
              sum += (64'd1 << (62 - i * (2 * k + 1))) / longint'(2 * k + 1);
            end
          end
        end
        atan_q[i] = longint'((sum + (64'd1 << (61 - ANG_FRAC))) >> (62 - ANG_FRAC));
        if (2 * i <= 62) p -= p / ((64'd1 << (2 * i)) + 1);
      end
      for (int k = 31; k >= 0; k--) begin
        cand = root | (64'd1 << k);
        if (cand * cand <= p) root = cand;
      end
      gain = longint'((root + 1) >> 1);
    endfunction

    function void set_regs(longint unsigned e, longint unsigned t, int unsigned n);
      ecc = e;
      tol = t;
      iter_max = n;
    endfunction

    // Range-reduced rotation CORDIC giving Q30 sine and cosine.
    function void rotate(input longint a, output longint s, output longint c);
      longint r;
      longint x;
      longint y;
      longint dx;
      longint dy;
      bit     flip;
      r = a % (pi_val * 2);
      x = gain;
      y = 0;
      flip = 0;
      if (r > pi_val) r -= pi_val * 2;
      else if (r < -pi_val) r += pi_val * 2;
      if (r > (pi_val >>> 1)) begin
        r -= pi_val;
        flip = 1;
      end else if (r < -(pi_val >>> 1)) begin
        r += pi_val;
        flip = 1;
      end
      for (int i = 0; i < ROT_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (r >= 0) begin
          x -= dx; y += dy; r -= atan_q[i];
        end else begin
          x += dx; y -= dy; r += atan_q[i];
        end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    // Restoring quotient |f| * 2^30 / f', saturated at 2^31.
    function longint unsigned newton_step(longint unsigned num, longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = num / den;
      r = num % den;
      for (int i = 0; i < 30; i++) begin
        if (q > (64'd1 << 31)) return 64'd1 << 31;
        q = q << 1;
        r = r << 1;
        if (r >= den) begin
          r -= den;
          q |= 1;
        end
      end
      return (q > (64'd1 << 31)) ? (64'd1 << 31) : q;
    endfunction

    // Solve one mean anomaly and queue the expected solution.
    function void note_input(logic signed [31:0] m_in);
      longint          m;
      longint          ea;
      longint          s;
      longint          c;
      longint          es;
      longint          f;
      longint          fp;
      longint unsigned mag;
      int unsigned     limit;
      int unsigned     n;
      bit              done;
      solution_t       sol;
      m = longint'(m_in);
      ea = m;
      n = 0;
      done = 0;
      limit = (iter_max == 0) ? 1 : (iter_max > 64 ? 64 : iter_max);
      while (n < limit && !done) begin
        rotate(ea, s, c);
        es = (longint'(ecc) * s + (64'sd1 << 31)) >>> 32;
        f = ea - es - m;
        fp = (64'sd1 << 30) - ((longint'(ecc) * c + (64'sd1 << 29)) >>> 30);
        if (fp < 1) fp = 1;
        mag = newton_step(f < 0 ? longint'(-f) : f, fp);
        ea = ea + (f > 0 ? -longint'(mag) : longint'(mag));
        if (ea > 64'sd2147483647) ea = 64'sd2147483647;
        if (ea < -64'sd2147483648) ea = -64'sd2147483648;
        n++;
        if (mag < tol) done = 1;
      end
      sol.anomaly = ea[31:0];
      sol.steps = n[6:0];
      sol.converged = done;
      pending.push_back(sol);
    endfunction

    function void check_result(solution_t got);
      solution_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result item E=%0d n=%0d conv=%0b", $time,
                 got.anomaly, got.steps, got.converged);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.anomaly !== want.anomaly) begin
        $display("%0t: eccentric_anomaly expected %0d actual %0d", $time,
                 want.anomaly, got.anomaly);
        errors++;
      end
      if (got.steps !== want.steps) begin
        $display("%0t: iterations_used expected %0d actual %0d", $time,
                 want.steps, got.steps);
        errors++;
      end
      if (got.converged !== want.converged) begin
        $display("%0t: converged expected %0b actual %0b", $time,
                 want.converged, got.converged);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [31:0] mean_anomaly_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] eccentric_anomaly_o;
  logic [6:0]         iterations_used_o;
  logic               converged_o;

  kepler_scoreboard solver_sb;
  bit               quiet;
  bit               hold_off_req;
  int               idle_cycles;

  kepler_equation_newton_solver i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .mean_anomaly_i      (mean_anomaly_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .eccentric_anomaly_o (eccentric_anomaly_o),
    .iterations_used_o   (iterations_used_o),
    .converged_o         (converged_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (quiet || r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(int addr, logic [31:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr[3:0];
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Withdraw the offered item first so that nothing is accepted meanwhile.
  task automatic configure(logic [31:0] e, logic [31:0] t, logic [31:0] n);
    in_valid_i = 1'b0;
    while (solver_sb.pending.size() != 0) @(posedge clk_i);
    write_reg(ADDR_ECC, e);
    write_reg(ADDR_TOL, t);
    write_reg(ADDR_ITER, n);
    solver_sb.set_regs(e[29:0], t[28:0], n[6:0]);
  endtask

  // Offer one item; valid stays high across back-to-back items.
  task automatic send_item(logic signed [31:0] m);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    mean_anomaly_i = m;
    do @(posedge clk_i); while (in_stall_o);
    solver_sb.note_input(m);
    @(negedge clk_i);
  endtask

  task automatic finish_items();
    in_valid_i = 1'b0;
  endtask

  function automatic logic signed [31:0] random_anomaly();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return $urandom;
    if (r == 1) return $signed($urandom_range(0, 32'h7FFFFFFF)) >>> $urandom_range(0, 30);
    return $signed($urandom_range(0, 1686629714)) - 843314857;
  endfunction

  // Receiver: random stalls, one long hold-off on request, result checks.
  initial begin
    int hold;
    out_stall_i = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = 2000;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i = 1'b1;
      end else begin
        hold = pick_gap();
        out_stall_i = (hold > 0);
        if (hold > 0) hold--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      solver_sb.check_result({eccentric_anomaly_o, iterations_used_o, converged_o});
    end
  end

  // Watchdog on cycles with no accepted item on either channel and no register access.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic signed [31:0] pi_fix;
    solver_sb = new();
    idle_cycles = 0;
    quiet = 1'b0;
    hold_off_req = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    mean_anomaly_i = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    pi_fix = solver_sb.pi_val[31:0];

    // Directed items at reset settings, then with a high eccentricity.
    quiet = 1'b1;
    send_item(32'sd0);
    send_item(32'sd268435456);
    send_item(-32'sd268435456);
    configure(32'h39999999, 32'd27, 32'd16);
    send_item(32'sd0);
    send_item(32'sd1);
    send_item(-32'sd1);
    send_item(32'h7FFFFFFF);
    send_item(32'h80000000);
    send_item(pi_fix);
    send_item(-pi_fix);
    send_item(pi_fix >>> 1);
    send_item(-(pi_fix >>> 1));
    send_item(pi_fix * 2 + 1);
    send_item(32'h55555555);
    send_item(32'hAAAAAAAA);
    // Derivative floor near E = 0 with eccentricity next to one.
    configure(32'h3FFFFFFF, 32'd0, 32'd64);
    send_item(32'sd0);
    send_item(32'sd3);
    send_item(32'h80000000);
    // Iteration limit zero and above the cap.
    configure(32'h20000000, 32'd27, 32'd0);
    send_item(32'sd100000000);
    configure(32'h20000000, 32'd268435456, 32'd127);
    send_item(-32'sd100000000);
    finish_items();
    quiet = 1'b0;

    // Zero eccentricity with a long receiver hold-off partway through.
    configure(32'd0, 32'd27, 32'd16);
    for (int i = 0; i < 300; i++) begin
      if (i == 100) hold_off_req = 1'b1;
      send_item(random_anomaly());
    end
    finish_items();

    configure(32'h3FFFFFFF, 32'd0, 32'd64);
    for (int i = 0; i < 12; i++) send_item(random_anomaly());
    finish_items();

    configure(32'h3FFFFFFF, 32'd268435456, 32'd1);
    for (int i = 0; i < 150; i++) send_item(random_anomaly());
    finish_items();

    configure($urandom_range(0, 32'h3FFFFFFF), $urandom_range(0, 5000), 32'd0);
    for (int i = 0; i < 100; i++) send_item(random_anomaly());
    finish_items();

    // Random settings, quiet stretches on alternate phases.
    for (int ph = 0; ph < 6; ph++) begin
      quiet = (ph % 2 == 1);
      configure($urandom_range(0, 32'h3FFFFFFF),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 268435456)
                                            : $urandom_range(0, 2000),
                $urandom_range(1, 16));
      for (int i = 0; i < 150; i++) send_item(random_anomaly());
      finish_items();
    end

    while (solver_sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (solver_sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
